// File: rtl/kcl_pkg.sv
package kcl_pkg;

  localparam int NUM_CODE_CHARS = 4;

  typedef logic [7:0] char_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_ECHO     = 3'd1,
    ACT_UNLOCKED = 3'd2,
    ACT_WRONG    = 3'd3,
    ACT_LOCKED   = 3'd4,
    ACT_CLEARED  = 3'd5,
    ACT_TEMP     = 3'd6,
    ACT_IGNORED  = 3'd7
  } action_t;

  typedef struct packed {
    logic [2:0] key_row;
    logic [2:0] key_col;
  } key_item_t;

  typedef struct packed {
    char_t   key_char;
    action_t action;
    logic    show_prompt;
    logic    logged_in_flag;
    logic    lock_open;
    logic    lock_close;
  } result_t;

  localparam char_t CHAR_NONE = 8'h00;
  localparam char_t CHAR_A    = 8'h41;
  localparam char_t CHAR_B    = 8'h42;
  localparam char_t CHAR_C    = 8'h43;

  // code after reset: '1' '2' '3' '4'
  localparam char_t CODE_RESET [NUM_CODE_CHARS] = '{8'h31, 8'h32, 8'h33, 8'h34};

  // keypad layout indexed by {row - 1, col - 1}
  localparam char_t LAYOUT [16] = '{
    8'h31, 8'h32, 8'h33, 8'h41,
    8'h34, 8'h35, 8'h36, 8'h42,
    8'h37, 8'h38, 8'h39, 8'h43,
    8'h2A, 8'h30, 8'h23, 8'h44
  };

endpackage

// File: rtl/kcl_if.sv
interface kcl_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] key_row;
  logic [2:0] key_col;

  modport source (output valid, output key_row, output key_col, input ready);
  modport sink   (input valid, input key_row, input key_col, output ready);
  modport mon    (input valid, input ready, input key_row, input key_col);
endinterface

interface kcl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_char;
  logic [2:0] action;
  logic       show_prompt;
  logic       logged_in_flag;
  logic       lock_open;
  logic       lock_close;

  modport source (output valid, output key_char, output action, output show_prompt,
                  output logged_in_flag, output lock_open, output lock_close,
                  input ready);
  modport sink   (input valid, input key_char, input action, input show_prompt,
                  input logged_in_flag, input lock_open, input lock_close,
                  output ready);
  modport mon    (input valid, input ready, input key_char, input action,
                  input show_prompt, input logged_in_flag, input lock_open,
                  input lock_close);
endinterface

interface kcl_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] idx;
  logic [7:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
  modport mon    (input valid, input ready, input idx, input data);
endinterface

// File: rtl/keypad_code_lock_unit.sv
// Four-character keypad code lock. Each input word carries one decoded key
// position (row 0 is no key); the block maps it through the 4x4 layout,
// tracks the entered characters, login and prompt state, and returns at most one
// result word per input word (none for an idle word with no prompt due).
// One input word is taken every clock cycle while out_ch does not stall; a word
// passes an input register and then the state update into the result register,
// from which its result is offered. Throughput is set only by out_ch.ready.
// The code registers are written through cfg_ch, which is always ready; write
// them only while no word is in flight.
module keypad_code_lock_unit (
  input  logic       clk,
  input  logic       rst_n,
  kcl_in_if.sink     in_ch,
  kcl_out_if.source  out_ch,
  kcl_cfg_if.sink    cfg_ch
);
  import kcl_pkg::*;

  logic      item_valid;
  key_item_t item;
  logic      take;
  logic      res_valid;
  result_t   res;

  logic      out_valid_r, out_valid_nxt;
  result_t   res_r;

  assign take         = item_valid && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  kcl_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  kcl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (take),
    .item      (item),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.idx),
    .cfg_data  (cfg_ch.data),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = res_valid;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.key_char       = res_r.key_char;
  assign out_ch.action         = res_r.action;
  assign out_ch.show_prompt    = res_r.show_prompt;
  assign out_ch.logged_in_flag = res_r.logged_in_flag;
  assign out_ch.lock_open      = res_r.lock_open;
  assign out_ch.lock_close     = res_r.lock_close;

endmodule

// File: rtl/kcl_in_reg.sv
module kcl_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  kcl_in_if.sink            in_ch,
  input  logic              take,
  output logic              item_valid,
  output kcl_pkg::key_item_t item
);
  import kcl_pkg::*;

  logic      valid_r;
  key_item_t item_r;

  // the register frees up in the same cycle its word moves on
  assign in_ch.ready = !valid_r || take;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.key_row <= in_ch.key_row;
      item_r.key_col <= in_ch.key_col;
    end
  end

endmodule

// File: rtl/kcl_core.sv
module kcl_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  kcl_pkg::key_item_t  item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  kcl_pkg::char_t      cfg_data,
  output logic                res_valid,
  output kcl_pkg::result_t    res
);
  import kcl_pkg::*;

  char_t      code_r    [NUM_CODE_CHARS];
  char_t      entered_r [NUM_CODE_CHARS];
  logic [2:0] count_r, count_nxt;
  logic       session_r, session_nxt;
  logic       prompt_r, prompt_nxt;

  logic       pos_ok;
  logic [1:0] row_idx;
  logic [1:0] col_idx;
  logic       match;
  logic       store;
  char_t      ch;
  action_t    act;
  logic       opened;
  logic       closed;

  assign pos_ok  = (item.key_row >= 3'd1) && (item.key_row <= 3'd4) &&
                   (item.key_col >= 3'd1) && (item.key_col <= 3'd4);
  assign row_idx = 2'(item.key_row - 3'd1);
  assign col_idx = 2'(item.key_col - 3'd1);

  // all four compares side by side
  assign match = (count_r == 3'd4) &&
                 (entered_r[0] == code_r[0]) && (entered_r[1] == code_r[1]) &&
                 (entered_r[2] == code_r[2]) && (entered_r[3] == code_r[3]);

  always_comb begin
    ch          = CHAR_NONE;
    act         = ACT_NONE;
    opened      = 1'b0;
    closed      = 1'b0;
    store       = 1'b0;
    res_valid   = 1'b1;
    count_nxt   = count_r;
    session_nxt = session_r;
    prompt_nxt  = 1'b0;
    if (item.key_row == 3'd0) begin
      res_valid = prompt_r;
    end else if (!pos_ok) begin
      act = ACT_IGNORED;
    end else begin
      ch = LAYOUT[{row_idx, col_idx}];
      if (ch == CHAR_A) begin
        if (session_r) begin
          act = ACT_IGNORED;
        end else if (match) begin
          session_nxt = 1'b1;
          opened      = 1'b1;
          act         = ACT_UNLOCKED;
        end else begin
          count_nxt = 3'd0;
          act       = ACT_WRONG;
        end
      end else if (ch == CHAR_B) begin
        count_nxt   = 3'd0;
        prompt_nxt  = 1'b1;
        session_nxt = 1'b0;
        if (session_r) begin
          closed = 1'b1;
          act    = ACT_LOCKED;
        end else begin
          act = ACT_CLEARED;
        end
      end else if (ch == CHAR_C) begin
        act = session_r ? ACT_TEMP : ACT_IGNORED;
      end else if (count_r < 3'd4) begin
        store     = 1'b1;
        count_nxt = count_r + 3'd1;
        act       = ACT_ECHO;
      end else begin
        act = ACT_IGNORED;
      end
    end
    res.key_char       = ch;
    res.action         = act;
    res.show_prompt    = prompt_r;
    res.logged_in_flag = session_nxt;
    res.lock_open      = opened;
    res.lock_close     = closed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= 3'd0;
      session_r <= 1'b0;
      prompt_r  <= 1'b1;
    end else if (fire) begin
      count_r   <= count_nxt;
      session_r <= session_nxt;
      prompt_r  <= prompt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CODE_CHARS; i++) begin
        code_r[i] <= CODE_RESET[i];
      end
    end else if (cfg_we) begin
      code_r[cfg_idx] <= cfg_data;
    end
  end

  // entry slots are only compared once all four are written
  always_ff @(posedge clk) begin
    if (fire && store) begin
      entered_r[count_r[1:0]] <= ch;
    end
  end

endmodule

// File: rtl/kcl_checker.sv
module kcl_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_key_char,
  input  logic [2:0] out_action,
  input  logic       out_logged_in_flag,
  input  logic       out_lock_open,
  input  logic       out_lock_close
);
  import kcl_pkg::*;

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_char) &&
    $stable(out_action) && $stable(out_logged_in_flag))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lock_open |->
    out_action == ACT_UNLOCKED && out_logged_in_flag && !out_lock_close)
    else $error("lock opened without a login");

  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lock_close |->
    out_action == ACT_LOCKED && !out_logged_in_flag)
    else $error("lock closed without a logout");

  a_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_TEMP |-> out_logged_in_flag)
    else $error("temperature requested while logged out");

endmodule

bind keypad_code_lock_unit kcl_checker u_kcl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_key_char       (out_ch.key_char),
  .out_action         (out_ch.action),
  .out_logged_in_flag (out_ch.logged_in_flag),
  .out_lock_open      (out_ch.lock_open),
  .out_lock_close     (out_ch.lock_close)
);
